// ===== hw/rtl/sspfq_pkg.sv =====
// shared types and constants for the spi slave packet framer queue
`timescale 1ns / 1ps
`default_nettype none
package sspfq_pkg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_ENQ   = 2'd1,
        REQ_POP   = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic REG_IRQ_POL = 1'b0;

endpackage
`default_nettype wire

// ===== hw/rtl/sspfq_ctrl.sv =====
// controller: input capture, execute and result beat hand-off
`timescale 1ns / 1ps
`default_nettype none
module sspfq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output sspfq_pkg::t_cmd    o_cmd
);
    import sspfq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   s_out_free;

    assign s_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (s_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = s_out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/sspfq_dp.sv =====
// datapath: transmit queue memory, receive framer and result registers
`timescale 1ns / 1ps
`default_nettype none
module sspfq_dp #(
    parameter int unsigned PACKET_BYTES = 8,
    parameter int unsigned QUEUE_DEPTH  = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sspfq_pkg::t_cmd i_cmd,
    input  wire logic [1:0]      i_req_type,
    input  wire logic            i_cs_low,
    input  wire logic            i_rx_valid,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic            i_tx_space,
    input  wire logic [63:0]     i_tx_packet,
    input  wire logic            i_irq_pol,
    output logic                 o_accepted,
    output logic [63:0]          o_rx_packet,
    output logic                 o_rx_ready,
    output logic                 o_tx_valid,
    output logic [7:0]           o_tx_byte,
    output logic                 o_irq_pin,
    output logic [2:0]           o_queued_packets
);
    import sspfq_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned RXC_W = $clog2(PACKET_BYTES + 1);
    localparam int unsigned POS_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [RXC_W-1:0] RXC_FULL = RXC_W'(PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_BYTES - 1);

    // captured request
    t_req        r_req;
    logic        r_cs;
    logic        r_rxv;
    logic [7:0]  r_rxb;
    logic        r_space;
    logic [63:0] r_txp;

    // transmit queue
    logic [63:0]      mem [QUEUE_DEPTH];
    logic [63:0]      r_rd_data;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_irq, n_irq;
    logic             s_wr;

    // receive framer
    logic [63:0]      r_rx_buf, n_rx_buf;
    logic [RXC_W-1:0] r_rx_cnt, n_rx_cnt;
    logic             r_rx_done, n_rx_done;
    logic             r_cs_was_low, n_cs_was_low;

    // result
    logic        s_accepted;
    logic [63:0] s_rx_packet;
    logic        s_tx_valid;
    logic [7:0]  s_tx_byte;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= t_req'(i_req_type);
            r_cs    <= i_cs_low;
            r_rxv   <= i_rx_valid;
            r_rxb   <= i_rx_byte;
            r_space <= i_tx_space;
            r_txp   <= i_tx_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && s_wr) begin
            mem[r_head] <= r_txp;
        end
        r_rd_data <= mem[r_tail];
    end

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_pos        = r_pos;
        n_irq        = r_irq;
        n_rx_buf     = r_rx_buf;
        n_rx_cnt     = r_rx_cnt;
        n_rx_done    = r_rx_done;
        n_cs_was_low = r_cs_was_low;
        s_wr         = 1'b0;
        s_accepted   = 1'b0;
        s_rx_packet  = '0;
        s_tx_valid   = 1'b0;
        s_tx_byte    = '0;
        unique case (r_req)
            REQ_TICK: begin
                if (r_cs && !r_cs_was_low) begin
                    n_rx_cnt     = '0;
                    n_rx_done    = 1'b0;
                    n_cs_was_low = 1'b1;
                end else if (!r_cs && r_cs_was_low) begin
                    n_rx_done    = (r_rx_cnt == RXC_FULL);
                    n_rx_cnt     = '0;
                    n_cs_was_low = 1'b0;
                end
                if (r_cs && r_rxv && (n_rx_cnt < RXC_FULL)) begin
                    for (int k = 0; k < PACKET_BYTES; k++) begin
                        if (n_rx_cnt == RXC_W'(k)) begin
                            n_rx_buf[k*8 +: 8] = r_rxb;
                        end
                    end
                    n_rx_cnt = n_rx_cnt + 1'b1;
                end
                if ((r_count != '0) && r_space) begin
                    s_tx_valid = 1'b1;
                    s_tx_byte  = r_rd_data[r_pos*8 +: 8];
                    if (r_pos == POS_LAST) begin
                        n_pos   = '0;
                        n_tail  = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                        n_count = r_count - 1'b1;
                        if (n_count == '0) begin
                            n_irq = 1'b0;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            REQ_ENQ: begin
                if (r_count < CNT_FULL) begin
                    s_wr       = 1'b1;
                    n_head     = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                    n_count    = r_count + 1'b1;
                    n_irq      = 1'b1;
                    s_accepted = 1'b1;
                end
            end
            REQ_POP: begin
                if (r_rx_done) begin
                    s_accepted  = 1'b1;
                    s_rx_packet = r_rx_buf;
                    n_rx_done   = 1'b0;
                end
            end
            REQ_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
                n_pos   = '0;
                n_irq   = 1'b0;
            end
            default: s_wr = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_pos        <= '0;
            r_irq        <= 1'b0;
            r_rx_buf     <= '0;
            r_rx_cnt     <= '0;
            r_rx_done    <= 1'b0;
            r_cs_was_low <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_pos        <= n_pos;
            r_irq        <= n_irq;
            r_rx_buf     <= n_rx_buf;
            r_rx_cnt     <= n_rx_cnt;
            r_rx_done    <= n_rx_done;
            r_cs_was_low <= n_cs_was_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_accepted       <= s_accepted;
            o_rx_packet      <= s_rx_packet;
            o_rx_ready       <= n_rx_done;
            o_tx_valid       <= s_tx_valid;
            o_tx_byte        <= s_tx_byte;
            o_irq_pin        <= ~(n_irq ^ i_irq_pol);
            o_queued_packets <= 3'(n_count);
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/spi_slave_packet_framer_queue.sv =====
// top level: spi slave packet framer with transmit queue and apb register
//
//  channel   direction  handshake              payload
//  request   in         i_in_valid/o_in_stall  req_type cs_low rx_valid rx_byte tx_space tx_packet
//  result    out        o_out_valid/i_out_stall accepted rx_packet rx_ready tx_valid tx_byte
//                                               irq_pin queued_packets
//  register  in         apb psel/penable       irq polarity at byte address 0
//
//  each item passes through two steps: capture, then execute into the result register
//  the queue memory read is registered, so execute uses the entry fetched at capture
//  a result beat that is stalled holds the execute step until the register frees
//  reset is synchronous; no clearing pass, queue entries are undefined until written
`timescale 1ns / 1ps
`default_nettype none
module spi_slave_packet_framer_queue #(
    parameter int unsigned PACKET_BYTES = 8,
    parameter int unsigned QUEUE_DEPTH  = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic                           i_cs_low,
    input  wire logic                           i_rx_valid,
    input  wire logic [7:0]                     i_rx_byte,
    input  wire logic                           i_tx_space,
    input  wire logic [63:0]                    i_tx_packet,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_accepted,
    output logic [63:0]                         o_rx_packet,
    output logic                                o_rx_ready,
    output logic                                o_tx_valid,
    output logic [7:0]                          o_tx_byte,
    output logic                                o_irq_pin,
    output logic [2:0]                          o_queued_packets,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sspfq_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [sspfq_pkg::DATA_W-1:0]   pwdata,
    output logic [sspfq_pkg::DATA_W-1:0]        prdata,
    output logic                                pready
);
    import sspfq_pkg::*;

    t_cmd s_cmd;
    logic r_irq_pol;
    logic s_reg_sel;

    assign pready    = 1'b1;
    assign s_reg_sel = (paddr[ADDR_W-1] == REG_IRQ_POL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_pol <= 1'b1;
        end else if (psel && penable && pwrite && pready && s_reg_sel) begin
            r_irq_pol <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (s_reg_sel) begin
            prdata[0] = r_irq_pol;
        end
    end

    sspfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (s_cmd)
    );

    sspfq_dp #(
        .PACKET_BYTES (PACKET_BYTES),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (s_cmd),
        .i_req_type        (i_req_type),
        .i_cs_low          (i_cs_low),
        .i_rx_valid        (i_rx_valid),
        .i_rx_byte         (i_rx_byte),
        .i_tx_space        (i_tx_space),
        .i_tx_packet       (i_tx_packet),
        .i_irq_pol         (r_irq_pol),
        .o_accepted        (o_accepted),
        .o_rx_packet       (o_rx_packet),
        .o_rx_ready        (o_rx_ready),
        .o_tx_valid        (o_tx_valid),
        .o_tx_byte         (o_tx_byte),
        .o_irq_pin         (o_irq_pin),
        .o_queued_packets  (o_queued_packets)
    );

endmodule
`default_nettype wire

// ===== dv/spi_slave_packet_framer_queue_tb.sv =====
// self-checking testbench for the spi slave packet framer queue
`timescale 1ns / 1ps
module spi_slave_packet_framer_queue_tb;
    import sspfq_pkg::*;

    localparam int PKT_BYTES  = 8;
    localparam int TXQ_DEPTH  = 4;
    localparam int HOLD_LEN   = 60;
    localparam int SETTLE     = 8;
    localparam int CYCLE_CAP  = 400000;
    localparam int PHASE_ITEMS = 575;
    localparam logic [ADDR_W-1:0] IRQ_POL_ADDR = ADDR_W'(4 * REG_IRQ_POL);

    typedef struct packed {
        t_req        req;
        logic        cs;
        logic        rv;
        logic [7:0]  rb;
        logic        sp;
        logic [63:0] pkt;
    } t_beat;

    typedef struct packed {
        logic        acc;
        logic [63:0] rxp;
        logic        rdy;
        logic        txv;
        logic [7:0]  txb;
        logic        irq;
        logic [2:0]  qp;
    } t_res;

    typedef struct packed {
        t_beat b;
        logic  fixed;
        t_res  r;
    } t_row;

    localparam t_res NO_RES = '0;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_req_type  = REQ_TICK;
    logic                i_cs_low    = 1'b0;
    logic                i_rx_valid  = 1'b0;
    logic [7:0]          i_rx_byte   = 8'h00;
    logic                i_tx_space  = 1'b0;
    logic [63:0]         i_tx_packet = 64'h0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_accepted;
    logic [63:0]         o_rx_packet;
    logic                o_rx_ready;
    logic                o_tx_valid;
    logic [7:0]          o_tx_byte;
    logic                o_irq_pin;
    logic [2:0]          o_queued_packets;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    spi_slave_packet_framer_queue #(
        .PACKET_BYTES (PKT_BYTES),
        .QUEUE_DEPTH  (TXQ_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_cs_low         (i_cs_low),
        .i_rx_valid       (i_rx_valid),
        .i_rx_byte        (i_rx_byte),
        .i_tx_space       (i_tx_space),
        .i_tx_packet      (i_tx_packet),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_accepted       (o_accepted),
        .o_rx_packet      (o_rx_packet),
        .o_rx_ready       (o_rx_ready),
        .o_tx_valid       (o_tx_valid),
        .o_tx_byte        (o_tx_byte),
        .o_irq_pin        (o_irq_pin),
        .o_queued_packets (o_queued_packets),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // framer mirror state
    logic [63:0] txq_mem [TXQ_DEPTH];
    int          txq_head, txq_tail, txq_cnt, txq_pos;
    logic [63:0] rx_buf;
    int          rx_cnt;
    logic        rx_rdy, sel_prev, irq_on, irq_high;

    t_res        framer_resp_q [$];
    t_row        dir_rows [25];
    int          err_cnt, cycle_cnt, items_sent, pkts_popped, tx_bytes, enq_refused;
    int          src_idle_pct, dst_idle_pct;
    bit          hold_pending;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string fld, input logic [63:0] got,
                                 input logic [63:0] exp);
        $display("mismatch %s: got %h expected %h (cycle %0d)", fld, got, exp, cycle_cnt);
        err_cnt++;
    endtask

    task automatic framer_predict(input t_beat b, output t_res r);
        r = '0;
        case (b.req)
            REQ_TICK: begin
                if (b.cs && !sel_prev) begin
                    rx_cnt   = 0;
                    rx_rdy   = 1'b0;
                    sel_prev = 1'b1;
                end else if (!b.cs && sel_prev) begin
                    rx_rdy   = (rx_cnt == PKT_BYTES);
                    rx_cnt   = 0;
                    sel_prev = 1'b0;
                end
                if (b.cs && b.rv && rx_cnt < PKT_BYTES) begin
                    rx_buf[8*rx_cnt +: 8] = b.rb;
                    rx_cnt++;
                end
                if (txq_cnt > 0 && b.sp) begin
                    r.txv = 1'b1;
                    r.txb = txq_mem[txq_tail][8*txq_pos +: 8];
                    tx_bytes++;
                    txq_pos++;
                    if (txq_pos >= PKT_BYTES) begin
                        txq_pos  = 0;
                        txq_tail = (txq_tail + 1) % TXQ_DEPTH;
                        txq_cnt--;
                        if (txq_cnt == 0)
                            irq_on = 1'b0;
                    end
                end
            end
            REQ_ENQ: begin
                if (txq_cnt < TXQ_DEPTH) begin
                    txq_mem[txq_head] = b.pkt;
                    txq_head = (txq_head + 1) % TXQ_DEPTH;
                    txq_cnt++;
                    irq_on = 1'b1;
                    r.acc  = 1'b1;
                end else begin
                    enq_refused++;
                end
            end
            REQ_POP: begin
                if (rx_rdy) begin
                    r.acc  = 1'b1;
                    r.rxp  = rx_buf;
                    rx_rdy = 1'b0;
                    pkts_popped++;
                end
            end
            default: begin
                txq_head = 0;
                txq_tail = 0;
                txq_cnt  = 0;
                txq_pos  = 0;
                irq_on   = 1'b0;
            end
        endcase
        r.rdy = rx_rdy;
        r.irq = (irq_on == irq_high);
        r.qp  = txq_cnt[2:0];
    endtask

    // offer one beat, predict once it is taken; called at a rising edge
    task automatic send_beat(input t_beat b, input logic fixed, input t_res fixed_res);
        t_res r;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_type  <= b.req;
        i_cs_low    <= b.cs;
        i_rx_valid  <= b.rv;
        i_rx_byte   <= b.rb;
        i_tx_space  <= b.sp;
        i_tx_packet <= b.pkt;
        i_in_valid  <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        framer_predict(b, r);
        framer_resp_q.push_back(fixed ? fixed_res : r);
        items_sent++;
    endtask

    function automatic t_beat rand_beat(input t_req req);
        t_beat b;
        b.req = req;
        b.cs  = 1'($urandom_range(1));
        b.rv  = 1'($urandom_range(1));
        b.rb  = 8'($urandom_range(255));
        b.sp  = 1'($urandom_range(1));
        b.pkt = {$urandom, $urandom};
        return b;
    endfunction

    function automatic t_beat tick_beat(input logic cs, input logic rv);
        t_beat b;
        b    = rand_beat(REQ_TICK);
        b.cs = cs;
        b.rv = rv;
        return b;
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (framer_resp_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_irq_polarity(input logic v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= IRQ_POL_ADDR;
        pwdata  <= DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        irq_high = v;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[0] !== v)
            flag_mismatch("irq polarity readback", 64'(prdata), 64'(v));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_sequence();
        int pick, n, len, k;
        pick = $urandom_range(99);
        if (pick < 55) begin
            // well-formed frame with transmit traffic alongside
            send_beat(tick_beat(1'b0, 1'($urandom_range(1))), 1'b0, NO_RES);
            n = 0;
            while (n < PKT_BYTES) begin
                k = ($urandom_range(4) != 0);
                send_beat(tick_beat(1'b1, k[0]), 1'b0, NO_RES);
                n += k;
                if ($urandom_range(7) == 0)
                    send_beat(rand_beat(REQ_ENQ), 1'b0, NO_RES);
            end
            send_beat(tick_beat(1'b0, 1'($urandom_range(1))), 1'b0, NO_RES);
            send_beat(rand_beat(REQ_POP), 1'b0, NO_RES);
            if ($urandom_range(3) == 0)
                send_beat(rand_beat(REQ_POP), 1'b0, NO_RES);
        end else if (pick < 70) begin
            len = $urandom_range(1, 5);
            for (k = 0; k < len; k++)
                send_beat(rand_beat(REQ_ENQ), 1'b0, NO_RES);
        end else if (pick < 80) begin
            // short, full-length or overlong frame
            send_beat(tick_beat(1'b0, 1'b1), 1'b0, NO_RES);
            len = $urandom_range(0, 12);
            for (k = 0; k < len; k++)
                send_beat(tick_beat(1'b1, 1'b1), 1'b0, NO_RES);
            send_beat(tick_beat(1'b0, 1'b1), 1'b0, NO_RES);
            send_beat(rand_beat(REQ_POP), 1'b0, NO_RES);
        end else if (pick < 88) begin
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++)
                send_beat(rand_beat(REQ_TICK), 1'b0, NO_RES);
        end else if (pick < 97) begin
            send_beat(rand_beat(t_req'(2'($urandom_range(3)))), 1'b0, NO_RES);
        end else begin
            send_beat(rand_beat(REQ_CLEAR), 1'b0, NO_RES);
        end
    endtask

    task automatic run_random(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
            run_sequence();
    endtask

    // receiver side: random stall, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_pending = 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < dst_idle_pct);
            end
        end
    end

    // result beat checker and run limit
    always @(posedge i_clk) begin
        t_res got, exp;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, framer_resp_q.size());
            $display("spi_slave_packet_framer_queue regression: fail");
            $finish;
        end else if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_accepted, o_rx_packet, o_rx_ready, o_tx_valid, o_tx_byte,
                    o_irq_pin, o_queued_packets};
            if (framer_resp_q.size() == 0) begin
                flag_mismatch("unexpected result beat", 64'(got.acc), 64'h0);
            end else begin
                exp = framer_resp_q.pop_front();
                if (got.acc !== exp.acc) flag_mismatch("accepted", 64'(got.acc), 64'(exp.acc));
                if (got.rxp !== exp.rxp) flag_mismatch("rx_packet", got.rxp, exp.rxp);
                if (got.rdy !== exp.rdy) flag_mismatch("rx_ready", 64'(got.rdy), 64'(exp.rdy));
                if (got.txv !== exp.txv) flag_mismatch("tx_valid", 64'(got.txv), 64'(exp.txv));
                if (got.txb !== exp.txb) flag_mismatch("tx_byte", 64'(got.txb), 64'(exp.txb));
                if (got.irq !== exp.irq) flag_mismatch("irq_pin", 64'(got.irq), 64'(exp.irq));
                if (got.qp !== exp.qp)
                    flag_mismatch("queued_packets", 64'(got.qp), 64'(exp.qp));
            end
        end
    end

    initial begin
        int i;
        txq_head = 0; txq_tail = 0; txq_cnt = 0; txq_pos = 0;
        rx_buf = '0; rx_cnt = 0; rx_rdy = 1'b0; sel_prev = 1'b0;
        irq_on = 1'b0; irq_high = 1'b1;
        err_cnt = 0; cycle_cnt = 0; items_sent = 0;
        pkts_popped = 0; tx_bytes = 0; enq_refused = 0;
        src_idle_pct = 23; dst_idle_pct = 73; hold_pending = 1'b0;

        dir_rows[0]  = '{'{REQ_POP,   1'b0, 1'b0, 8'h00, 1'b0, 64'h0}, 1'b1,
                         '{1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0, 3'd0}};
        dir_rows[1]  = '{'{REQ_TICK,  1'b0, 1'b1, 8'hff, 1'b1, 64'h0}, 1'b1,
                         '{1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0, 3'd0}};
        dir_rows[2]  = '{'{REQ_ENQ,   1'b0, 1'b0, 8'h00, 1'b0, 64'hffff_ffff_ffff_ffff},
                         1'b1, '{1'b1, 64'h0, 1'b0, 1'b0, 8'h00, 1'b1, 3'd1}};
        dir_rows[3]  = '{'{REQ_ENQ,   1'b1, 1'b1, 8'hff, 1'b1, 64'h0}, 1'b1,
                         '{1'b1, 64'h0, 1'b0, 1'b0, 8'h00, 1'b1, 3'd2}};
        dir_rows[4]  = '{'{REQ_ENQ,   1'b0, 1'b0, 8'h00, 1'b0, 64'h0123_4567_89ab_cdef},
                         1'b1, '{1'b1, 64'h0, 1'b0, 1'b0, 8'h00, 1'b1, 3'd3}};
        dir_rows[5]  = '{'{REQ_ENQ,   1'b0, 1'b0, 8'h00, 1'b0, 64'h8000_0000_0000_0001},
                         1'b1, '{1'b1, 64'h0, 1'b0, 1'b0, 8'h00, 1'b1, 3'd4}};
        // queue full
        dir_rows[6]  = '{'{REQ_ENQ,   1'b0, 1'b0, 8'h00, 1'b0, 64'h5555_5555_5555_5555},
                         1'b1, '{1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b1, 3'd4}};
        dir_rows[7]  = '{'{REQ_TICK,  1'b1, 1'b1, 8'h00, 1'b1, 64'h0}, 1'b1,
                         '{1'b0, 64'h0, 1'b0, 1'b1, 8'hff, 1'b1, 3'd4}};
        dir_rows[8]  = '{'{REQ_TICK,  1'b1, 1'b1, 8'h01, 1'b1, 64'h0}, 1'b0, NO_RES};
        dir_rows[9]  = '{'{REQ_TICK,  1'b1, 1'b1, 8'h80, 1'b1, 64'h0}, 1'b0, NO_RES};
        dir_rows[10] = '{'{REQ_TICK,  1'b1, 1'b1, 8'h7f, 1'b1, 64'h0}, 1'b0, NO_RES};
        dir_rows[11] = '{'{REQ_TICK,  1'b1, 1'b1, 8'h55, 1'b1, 64'h0}, 1'b0, NO_RES};
        dir_rows[12] = '{'{REQ_TICK,  1'b1, 1'b1, 8'haa, 1'b1, 64'h0}, 1'b0, NO_RES};
        dir_rows[13] = '{'{REQ_TICK,  1'b1, 1'b1, 8'hc3, 1'b1, 64'h0}, 1'b0, NO_RES};
        dir_rows[14] = '{'{REQ_TICK,  1'b1, 1'b1, 8'hff, 1'b1, 64'h0}, 1'b0, NO_RES};
        // overlong frame, then select released with a byte
        dir_rows[15] = '{'{REQ_TICK,  1'b1, 1'b1, 8'haa, 1'b0, 64'h0}, 1'b0, NO_RES};
        dir_rows[16] = '{'{REQ_TICK,  1'b0, 1'b1, 8'h3c, 1'b0, 64'h0}, 1'b0, NO_RES};
        dir_rows[17] = '{'{REQ_POP,   1'b0, 1'b0, 8'h00, 1'b0, 64'h0}, 1'b0, NO_RES};
        dir_rows[18] = '{'{REQ_POP,   1'b0, 1'b0, 8'h00, 1'b0, 64'h0}, 1'b1,
                         '{1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b1, 3'd3}};
        // short frame, with clear mid packet
        dir_rows[19] = '{'{REQ_TICK,  1'b1, 1'b1, 8'h5a, 1'b1, 64'h0}, 1'b0, NO_RES};
        dir_rows[20] = '{'{REQ_TICK,  1'b0, 1'b0, 8'h00, 1'b0, 64'h0}, 1'b0, NO_RES};
        dir_rows[21] = '{'{REQ_CLEAR, 1'b1, 1'b1, 8'hff, 1'b1, 64'hffff_ffff_ffff_ffff},
                         1'b1, '{1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0, 3'd0}};
        dir_rows[22] = '{'{REQ_TICK,  1'b0, 1'b0, 8'h00, 1'b1, 64'h0}, 1'b1,
                         '{1'b0, 64'h0, 1'b0, 1'b0, 8'h00, 1'b0, 3'd0}};
        dir_rows[23] = '{'{REQ_ENQ,   1'b0, 1'b0, 8'h00, 1'b0, 64'h1122_3344_5566_7788},
                         1'b0, NO_RES};
        dir_rows[24] = '{'{REQ_TICK,  1'b1, 1'b1, 8'h96, 1'b1, 64'h0}, 1'b0, NO_RES};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < 25; i++)
            send_beat(dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].r);
        wait_drained();

        set_irq_polarity(1'b0);
        run_random(PHASE_ITEMS / 2);
        hold_pending = 1'b1;
        run_random(PHASE_ITEMS / 2);
        wait_drained();

        src_idle_pct = 73;
        dst_idle_pct = 23;
        set_irq_polarity(1'b1);
        run_random(PHASE_ITEMS);
        wait_drained();

        src_idle_pct = 0;
        dst_idle_pct = 0;
        set_irq_polarity(1'b0);
        hold_pending = 1'b1;
        run_random(PHASE_ITEMS);
        wait_drained();

        $display("covered %0d items over three idling and polarity settings, with hold-offs",
                 items_sent);
        $display("popped %0d packets, emitted %0d transmit bytes, refused %0d enqueues",
                 pkts_popped, tx_bytes, enq_refused);
        if (err_cnt == 0) begin
            $display("spi_slave_packet_framer_queue regression: pass");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("spi_slave_packet_framer_queue regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sspfq_pkg.sv
hw/rtl/sspfq_ctrl.sv
hw/rtl/sspfq_dp.sv
hw/rtl/spi_slave_packet_framer_queue.sv
dv/spi_slave_packet_framer_queue_tb.sv
